### src/adjacency_matrix_query_engine_core_defines.svh
// Assertion macros for the adjacency matrix query engine checker.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef ADJACENCY_MATRIX_QUERY_ENGINE_CORE_DEFINES_SVH
`define ADJACENCY_MATRIX_QUERY_ENGINE_CORE_DEFINES_SVH

// clocked assertion, off while reset is held
`define AMQE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("amqe assertion failed");

// clocked assertion that also holds through reset
`define AMQE_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("amqe reset assertion failed");

`endif

### src/amqe_pkg.sv
// Shared types, request codes and row helpers for the adjacency matrix engine.
// No dependencies.
package amqe_pkg;

  localparam int NODES = 32;
  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = $clog2(NODES + 1);

  typedef logic [NODES-1:0] row_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    REQ_INIT   = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_ANY    = 3'd2,
    REQ_NBR    = 3'd3,
    REQ_THRESH = 3'd4,
    REQ_NEXT   = 3'd5,
    REQ_MAX    = 3'd6
  } req_t;

  function automatic row_t col_mask(input cnt_t n);
    row_t m;
    for (int i = 0; i < NODES; i++) begin
      m[i] = (CNT_W'(i) < n);
    end
    return m;
  endfunction

  function automatic cnt_t pop_count(input row_t v);
    cnt_t c;
    c = '0;
    for (int i = 0; i < NODES; i++) begin
      c = c + CNT_W'(v[i]);
    end
    return c;
  endfunction

  function automatic idx_t low_index(input row_t v);
    idx_t k;
    k = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (v[i]) begin
        k = IDX_W'(i);
      end
    end
    return k;
  endfunction

endpackage

### src/amqe_ram.sv
// Edge matrix store: one row per entry, one write and one registered read port.
// Depends on amqe_pkg.
module amqe_ram (
  input  logic           clk,
  input  logic           wr_en,
  input  amqe_pkg::idx_t wr_addr,
  input  amqe_pkg::row_t wr_data,
  input  amqe_pkg::idx_t rd_addr,
  output amqe_pkg::row_t rd_data
);
  import amqe_pkg::*;

  row_t mem [NODES];
  row_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### src/adjacency_matrix_query_engine_core.sv
// Adjacency matrix query engine top level: request sequencer around the row store.
// Depends on amqe_pkg and amqe_ram.
//
// Input channel (in_valid/in_stall) takes one request beat; the output channel
// (out_valid/out_stall) gives result beats, out_last marking the final one.
// One request is worked at a time; in_stall is high until it is finished, and
// a finished beat may still wait in the output register while the next is taken.
// Steps per request, with n the node count in use:
//   init: all 32 rows written, one per cycle; write edge: read, then write back;
//   any / threshold / next row / max degree: a scan of up to n rows (one
//   store read and one popcount per row), then the beat goes out; neighbours:
//   row fetched, then one beat per cycle unless stalled, lowest column first.
// Requests with no result and code 7 give nothing.
// Reset (rst_n low, synchronous) empties the matrix at once through per-row valid
// bits, sets node_count to 32 and drops any pending beat. No clearing pass.
// While out_stall is high the held beat stays and the sequencer waits at its
// next beat. cfg_wr_en writes node_count; write it only while the block is idle.
module adjacency_matrix_query_engine_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_req_type,
  input  logic [4:0] in_row_index,
  input  logic [4:0] in_col_index,
  input  logic       in_edge_value,
  input  logic [5:0] in_degree_needed,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_result_value,
  output logic       out_found,
  output logic       out_last
);
  import amqe_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_WR_WB,
    ST_SCAN,
    ST_NB_LOAD,
    ST_NB_EMIT,
    ST_EMIT
  } st_t;

  st_t        state_r;
  req_t       req_r;
  idx_t       row_r;
  idx_t       col_r;
  logic       val_r;
  cnt_t       need_r;
  idx_t       idx_r;
  cnt_t       best_r;
  row_t       bits_r;
  logic       term_r;
  cnt_t       res_value_r;
  logic       res_found_r;
  row_t       row_vld_r;
  logic       vld_q_r;
  cnt_t       node_count_r;
  logic       out_valid_r;
  cnt_t       out_value_r;
  logic       out_found_r;
  logic       out_last_r;

  cnt_t       n_eff;
  cnt_t       n_m1;
  row_t       mask;
  logic       accept;
  logic       out_free;
  logic       beat_go;
  req_t       in_req;
  idx_t       rd_addr;
  row_t       rd_data;
  row_t       raw_row;
  row_t       row_data;
  cnt_t       row_cnt;
  logic       wr_en;
  idx_t       wr_addr;
  row_t       wr_data;
  row_t       col_bit;
  logic       scan_end;
  logic       scan_done;
  cnt_t       scan_value;
  logic       scan_found;
  cnt_t       best_nxt;
  idx_t       lo_idx;
  row_t       bits_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CNT_W'(NODES);
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (node_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (node_count_r > CNT_W'(NODES)) begin
      n_eff = CNT_W'(NODES);
    end else begin
      n_eff = node_count_r;
    end
  end

  assign n_m1     = n_eff - CNT_W'(1);
  assign mask     = col_mask(n_eff);
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_req   = req_t'(in_req_type);
  assign beat_go  = out_free && ((state_r == ST_EMIT) ||
                    (state_r == ST_NB_EMIT && (bits_r != '0 || term_r)));

  always_comb begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_req == REQ_ANY || in_req == REQ_THRESH || in_req == REQ_MAX) begin
          rd_addr = '0;
        end else begin
          rd_addr = in_row_index;
        end
      end
      ST_SCAN: rd_addr = idx_r + IDX_W'(1);
      default: rd_addr = row_r;
    endcase
  end

  amqe_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign raw_row  = rd_data & {NODES{vld_q_r}};
  assign row_data = raw_row & mask;
  assign row_cnt  = pop_count(row_data);
  assign col_bit  = row_t'(1) << col_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = row_r;
    wr_data = '0;
    if (state_r == ST_INIT) begin
      wr_en   = 1'b1;
      wr_addr = idx_r;
      if ({1'b0, idx_r} < n_eff) begin
        wr_data = mask & ~(row_t'(1) << idx_r);
      end
    end else if (state_r == ST_WR_WB) begin
      wr_en   = 1'b1;
      wr_data = val_r ? (raw_row | col_bit) : (raw_row & ~col_bit);
    end
  end

  assign scan_end = ({1'b0, idx_r} == n_m1);
  assign best_nxt = (row_cnt > best_r) ? row_cnt : best_r;

  always_comb begin
    scan_done  = scan_end;
    scan_value = '0;
    scan_found = 1'b0;
    unique case (req_r)
      REQ_ANY: begin
        scan_found = (row_data != '0);
        scan_done  = scan_end || scan_found;
      end
      REQ_THRESH: begin
        scan_found = (row_cnt >= need_r);
        scan_done  = scan_end || scan_found;
        scan_value = scan_found ? {1'b0, idx_r} : '0;
      end
      REQ_NEXT: begin
        scan_found = (row_data != '0);
        scan_done  = scan_end || scan_found;
        scan_value = scan_found ? {1'b0, idx_r} : '0;
      end
      REQ_MAX: begin
        scan_found = 1'b1;
        scan_value = best_nxt;
      end
      default: begin
        scan_done = 1'b1;
      end
    endcase
  end

  assign lo_idx   = low_index(bits_r);
  assign bits_nxt = bits_r & ~(row_t'(1) << lo_idx);

  always_ff @(posedge clk) begin
    vld_q_r <= row_vld_r[rd_addr];
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (beat_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            req_r  <= in_req;
            row_r  <= in_row_index;
            col_r  <= in_col_index;
            val_r  <= in_edge_value;
            need_r <= in_degree_needed;
            idx_r  <= (in_req == REQ_NEXT) ? in_row_index : '0;
            best_r <= '0;
            unique case (in_req)
              REQ_INIT: state_r <= ST_INIT;
              REQ_WRITE: begin
                if ({1'b0, in_row_index} < n_eff && {1'b0, in_col_index} < n_eff) begin
                  state_r <= ST_WR_WB;
                end
              end
              REQ_ANY, REQ_THRESH, REQ_MAX: state_r <= ST_SCAN;
              REQ_NEXT: begin
                if ({1'b0, in_row_index} < n_eff) begin
                  state_r <= ST_SCAN;
                end else begin
                  res_value_r <= '0;
                  res_found_r <= 1'b0;
                  state_r     <= ST_EMIT;
                end
              end
              REQ_NBR: state_r <= ST_NB_LOAD;
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_INIT: begin
          idx_r <= idx_r + IDX_W'(1);
          if (idx_r == IDX_W'(NODES - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_WR_WB: state_r <= ST_IDLE;
        ST_SCAN: begin
          idx_r  <= idx_r + IDX_W'(1);
          best_r <= best_nxt;
          if (scan_done) begin
            res_value_r <= scan_value;
            res_found_r <= scan_found;
            state_r     <= ST_EMIT;
          end
        end
        ST_NB_LOAD: begin
          if ({1'b0, row_r} < n_eff) begin
            bits_r <= row_data;
            term_r <= (row_cnt != n_m1);
          end else begin
            bits_r <= '0;
            term_r <= (n_m1 != '0);
          end
          state_r <= ST_NB_EMIT;
        end
        ST_NB_EMIT: begin
          if (out_free) begin
            if (bits_r != '0) begin
              out_value_r <= {1'b0, lo_idx};
              out_found_r <= 1'b1;
              out_last_r  <= (bits_nxt == '0) && !term_r;
              bits_r      <= bits_nxt;
              if (bits_nxt == '0 && !term_r) begin
                state_r <= ST_IDLE;
              end
            end else if (term_r) begin
              out_value_r <= '0;
              out_found_r <= 1'b0;
              out_last_r  <= 1'b1;
              state_r     <= ST_IDLE;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_value_r <= res_value_r;
            out_found_r <= res_found_r;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_found        = out_found_r;
  assign out_last         = out_last_r;

endmodule

### src/amqe_checker.sv
// Port-level checker for the adjacency matrix query engine, bound to the top level.
// Depends on amqe_pkg and adjacency_matrix_query_engine_core_defines.svh.
`include "adjacency_matrix_query_engine_core_defines.svh"

module amqe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [2:0] in_req_type,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] out_result_value,
  input logic       out_found,
  input logic       out_last
);
  import amqe_pkg::*;

  // no beat survives reset
  `AMQE_ASSERT_RST(a_rst_no_beat, !rst_n |=> !out_valid)
  // stalled beat holds
  `AMQE_ASSERT(a_stall_hold, out_valid && out_stall |=> out_valid && $stable(out_result_value))
  // only the terminator carries found low, and it always closes the request
  `AMQE_ASSERT(a_term_last, out_valid && !out_last |-> out_found)
  // a not-found beat reports zero
  `AMQE_ASSERT(a_none_zero, out_valid && !out_found |-> out_result_value == 6'd0)
  // an init sweep always occupies the block afterwards
  `AMQE_ASSERT(a_init_busy, in_valid && !in_stall && in_req_type == REQ_INIT |=> in_stall)

endmodule

bind adjacency_matrix_query_engine_core amqe_checker u_amqe_checker (.*);

### verif/tb_top.sv
// Self-checking bench for adjacency_matrix_query_engine_core: a graph model checks every
// result beat in order. Needs amqe_pkg (request codes, NODES, row_t) and the core itself.
`timescale 1ns / 100ps

module tb_top;
  import amqe_pkg::*;

  localparam logic [2:0] REQ_SPARE = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 32;

  typedef struct packed {
    logic [5:0] value;
    logic       found;
    logic       last;
  } answer_t;

  class graph_answer_board;
    row_t    adj[NODES];
    int      nodes_used;
    answer_t pending_answers[$];
    int      fails;

    function new();
      foreach (adj[i]) adj[i] = '0;
      nodes_used = NODES;
      fails = 0;
    endfunction

    function void set_nodes(logic [5:0] v);
      if (v == 0) nodes_used = 1;
      else if (v > NODES) nodes_used = NODES;
      else nodes_used = int'(v);
    endfunction

    function void push_answer(int value, logic found, logic last);
      answer_t a;
      a.value = 6'(value);
      a.found = found;
      a.last = last;
      pending_answers = {pending_answers, a};
    endfunction

    // works out the result beats of one accepted request
    function void take_request(logic [2:0] req, logic [4:0] row, logic [4:0] col,
                               logic val, logic [5:0] need);
      row_t    used;
      row_t    bits;
      answer_t nbr[$];
      answer_t a;
      bit      hit;
      int      best;
      used = {NODES{1'b1}};
      used = used >> (NODES - nodes_used);
      hit = 1'b0;
      best = 0;
      case (req)
        REQ_INIT: begin
          for (int i = 0; i < NODES; i++)
            adj[i] = (i < nodes_used) ? (used & ~(row_t'(1) << i)) : '0;
        end
        REQ_WRITE: begin
          if (row < nodes_used && col < nodes_used) adj[row][col] = val;
        end
        REQ_ANY: begin
          for (int i = 0; i < nodes_used; i++)
            if ((adj[i] & used) != '0) hit = 1'b1;
          push_answer(0, hit, 1'b1);
        end
        REQ_NBR: begin
          bits = (row < nodes_used) ? (adj[row] & used) : '0;
          for (int i = 0; i < nodes_used; i++) begin
            if (bits[i]) begin
              a.value = 6'(i);
              a.found = 1'b1;
              a.last = 1'b0;
              nbr = {nbr, a};
            end
          end
          if (nbr.size() != nodes_used - 1) begin
            a = '0;
            nbr = {nbr, a};
          end
          if (nbr.size() > 0) nbr[nbr.size() - 1].last = 1'b1;
          foreach (nbr[i]) pending_answers = {pending_answers, nbr[i]};
        end
        REQ_THRESH: begin
          for (int i = 0; i < nodes_used; i++) begin
            if (!hit && $countones(adj[i] & used) >= need) begin
              push_answer(i, 1'b1, 1'b1);
              hit = 1'b1;
            end
          end
          if (!hit) push_answer(0, 1'b0, 1'b1);
        end
        REQ_NEXT: begin
          for (int i = int'(row); i < nodes_used; i++) begin
            if (!hit && (adj[i] & used) != '0) begin
              push_answer(i, 1'b1, 1'b1);
              hit = 1'b1;
            end
          end
          if (!hit) push_answer(0, 1'b0, 1'b1);
        end
        REQ_MAX: begin
          for (int i = 0; i < nodes_used; i++)
            if ($countones(adj[i] & used) > best) best = $countones(adj[i] & used);
          push_answer(best, 1'b1, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_answer(logic [5:0] value, logic found, logic last);
      answer_t exp_beat;
      if (pending_answers.size() == 0) begin
        $error("result beat with nothing expected: result_value %0d found %0d last %0d",
               value, found, last);
        fails++;
        return;
      end
      exp_beat = pending_answers.pop_front();
      if (value !== exp_beat.value) begin
        $error("result_value: expected %0d, actual %0d", exp_beat.value, value);
        fails++;
      end
      if (found !== exp_beat.found) begin
        $error("found: expected %0d, actual %0d", exp_beat.found, found);
        fails++;
      end
      if (last !== exp_beat.last) begin
        $error("last: expected %0d, actual %0d", exp_beat.last, last);
        fails++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [5:0] cfg_wr_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_req_type = '0;
  logic [4:0] in_row_index = '0;
  logic [4:0] in_col_index = '0;
  logic       in_edge_value = 1'b0;
  logic [5:0] in_degree_needed = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [5:0] out_result_value;
  logic       out_found;
  logic       out_last;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;

  graph_answer_board board = new();

  adjacency_matrix_query_engine_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_edge_value    (in_edge_value),
    .in_degree_needed (in_degree_needed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_found        (out_found),
    .out_last         (out_last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_answer(out_result_value, out_found, out_last);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_request(input logic [2:0] req, input logic [4:0] row,
                              input logic [4:0] col, input logic val,
                              input logic [5:0] need);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_row_index <= row;
    in_col_index <= col;
    in_edge_value <= val;
    in_degree_needed <= need;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_request(req, row, col, val, need);
  endtask

  task automatic hold_until_drained();
    if (board.pending_answers.size() != 0) begin
      in_valid <= 1'b0;
      while (board.pending_answers.size() != 0) @(posedge clk);
    end
  endtask

  // no-result requests may still be busy once the last beat is out
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [5:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    board.set_nodes(v);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic directed_requests();
    send_request(REQ_ANY, 5'd0, 5'd0, 1'b0, 6'd0);
    send_request(REQ_MAX, 5'd0, 5'd0, 1'b0, 6'd0);
    send_request(REQ_NBR, 5'd0, 5'd31, 1'b1, 6'd0);
    send_request(REQ_THRESH, 5'd0, 5'd0, 1'b0, 6'd0);
    send_request(REQ_THRESH, 5'd0, 5'd0, 1'b0, 6'd32);
    send_request(REQ_NEXT, 5'd0, 5'd0, 1'b0, 6'd0);
    send_request(REQ_INIT, 5'd31, 5'd31, 1'b1, 6'd31);
    send_request(REQ_ANY, 5'd0, 5'd0, 1'b0, 6'd0);
    send_request(REQ_NBR, 5'd5, 5'd0, 1'b0, 6'd0);
    send_request(REQ_MAX, 5'd0, 5'd0, 1'b0, 6'd0);
    send_request(REQ_THRESH, 5'd0, 5'd0, 1'b0, 6'd31);
    send_request(REQ_THRESH, 5'd0, 5'd0, 1'b0, 6'd32);
    send_request(REQ_WRITE, 5'd5, 5'd5, 1'b1, 6'd0);
    send_request(REQ_NBR, 5'd5, 5'd0, 1'b0, 6'd0);
    send_request(REQ_THRESH, 5'd0, 5'd0, 1'b0, 6'd32);
    send_request(REQ_MAX, 5'd0, 5'd0, 1'b0, 6'd0);
    send_request(REQ_WRITE, 5'd0, 5'd31, 1'b0, 6'd0);
    send_request(REQ_NBR, 5'd0, 5'd0, 1'b0, 6'd0);
    send_request(REQ_NEXT, 5'd31, 5'd0, 1'b0, 6'd0);
    send_request(REQ_SPARE, 5'd31, 5'd31, 1'b1, 6'd32);
    send_request(REQ_WRITE, 5'd31, 5'd30, 1'b1, 6'd0);
    send_request(REQ_NEXT, 5'd31, 5'd0, 1'b0, 6'd0);
    hold_until_drained();
    send_request(REQ_ANY, 5'd0, 5'd0, 1'b0, 6'd0);
  endtask

  task automatic run_phase(input int nodes, input int idle_pct, input int stall_pct);
    logic [2:0] req;
    logic [4:0] row;
    logic [4:0] col;
    logic       val;
    logic [5:0] need;
    int         r;
    settle();
    write_node_count(6'(nodes));
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    send_request(REQ_INIT, 5'($urandom), 5'($urandom), 1'($urandom), 6'($urandom_range(32)));
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      r = $urandom_range(99);
      row = 5'($urandom);
      col = 5'($urandom);
      val = 1'($urandom);
      need = 6'($urandom_range(32));
      if (r < 6) begin
        req = 3'($urandom);
      end else if (r < 10) begin
        req = REQ_INIT;
      end else if (r < 50) begin
        req = REQ_WRITE;
        if (r >= 14) begin
          row = 5'($urandom_range(nodes - 1));
          col = 5'($urandom_range(nodes - 1));
        end
      end else begin
        case ($urandom_range(4))
          0: req = REQ_ANY;
          1: req = REQ_NBR;
          2: req = REQ_THRESH;
          3: req = REQ_NEXT;
          default: req = REQ_MAX;
        endcase
        if (r >= 55) begin
          row = 5'($urandom_range(nodes - 1));
          if ($urandom_range(1)) need = 6'($urandom_range(nodes));
        end
      end
      if (k == PHASE_ITEMS / 2) hold_until_drained();
      send_request(req, row, col, val, need);
    end
  endtask

  initial begin
    int idle_pcts[4];
    int stall_pcts[4];
    int phase_nodes[8];
    idle_pcts = '{0, 57, 0, 25};
    stall_pcts = '{0, 0, 57, 25};
    phase_nodes = '{32, 1, 2, 17, 31, 0, 32, 1};
    phase_nodes[5] = $urandom_range(3, 30);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_requests();
    for (int p = 0; p < 8; p++)
      run_phase(phase_nodes[p], idle_pcts[p % 4], stall_pcts[p % 4]);
    settle();
    if (board.pending_answers.size() != 0) begin
      $error("%0d expected result beats never arrived", board.pending_answers.size());
      board.fails++;
    end
    if (board.fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/amqe_pkg.sv
src/amqe_ram.sv
src/adjacency_matrix_query_engine_core.sv
src/amqe_checker.sv
verif/tb_top.sv
